// ===== design/complex_fixed_point_alu_unit_assert.svh =====
// assertion helpers for the complex arithmetic unit
`ifndef COMPLEX_FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define COMPLEX_FIXED_POINT_ALU_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CFPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfpa assertion failed");

// next-cycle implication, checked outside reset
`define CFPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfpa assertion failed");

`endif

// ===== design/cfpa_pkg.sv =====
package cfpa_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic       vld;
    logic [1:0] op;
    logic       dz;
    logic       sat;
    logic       neg_re;
    logic       neg_im;
  } ctl_t;

endpackage

// ===== design/cfpa_front.sv =====
module cfpa_front #(
  parameter int DATA_WIDTH = cfpa_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cfpa_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   req,
  input  logic [1:0]                             action,
  input  logic signed [DATA_WIDTH-1:0]           a_re,
  input  logic signed [DATA_WIDTH-1:0]           a_im,
  input  logic signed [DATA_WIDTH-1:0]           b_re,
  input  logic signed [DATA_WIDTH-1:0]           b_im,
  output cfpa_pkg::ctl_t                         ctl,
  output logic [DATA_WIDTH-1:0]                  pre_re,
  output logic [DATA_WIDTH-1:0]                  pre_im,
  output logic [2*DATA_WIDTH+FRAC_BITS:0]        num_re,
  output logic [2*DATA_WIDTH+FRAC_BITS:0]        num_im,
  output logic [2*DATA_WIDTH:0]                  den
);

  localparam int W  = DATA_WIDTH;
  localparam int NW = 2*W+1+FRAC_BITS;
  localparam logic signed [2*W:0] MAXV = {{(W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [2*W:0] MINV = {{(W+2){1'b1}}, {(W-1){1'b0}}};

  function automatic logic [W:0] clipw(input logic signed [2*W:0] x);
    logic [W:0] r;
    if (x > MAXV) begin
      r = {1'b1, MAXV[W-1:0]};
    end else if (x < MINV) begin
      r = {1'b1, MINV[W-1:0]};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  logic                    s1_vld_r;
  logic [1:0]              s1_op_r;
  logic signed [W-1:0]     ar_r, ai_r, br_r, bi_r;

  logic                    s2_vld_r;
  logic [1:0]              s2_op_r;
  logic signed [2*W-1:0]   p_rr_r, p_ii_r, p_ri_r, p_ir_r, q_rr_r, q_ii_r;
  logic signed [W:0]       as_re_r, as_im_r;
  logic signed [W:0]       as_re_nxt, as_im_nxt;

  cfpa_pkg::ctl_t          ctl_r, ctl_nxt;
  logic [W-1:0]            pre_re_r, pre_im_r, pre_re_nxt, pre_im_nxt;
  logic [NW-1:0]           num_re_r, num_im_r, num_re_nxt, num_im_nxt;
  logic [2*W:0]            den_r, den_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      ctl_r    <= '0;
    end else begin
      s1_vld_r <= req;
      s2_vld_r <= s1_vld_r;
      ctl_r    <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r  <= action;
    ar_r     <= a_re;
    ai_r     <= a_im;
    br_r     <= b_re;
    bi_r     <= b_im;
    s2_op_r  <= s1_op_r;
    p_rr_r   <= ar_r * br_r;
    p_ii_r   <= ai_r * bi_r;
    p_ri_r   <= ar_r * bi_r;
    p_ir_r   <= ai_r * br_r;
    q_rr_r   <= br_r * br_r;
    q_ii_r   <= bi_r * bi_r;
    as_re_r  <= as_re_nxt;
    as_im_r  <= as_im_nxt;
    pre_re_r <= pre_re_nxt;
    pre_im_r <= pre_im_nxt;
    num_re_r <= num_re_nxt;
    num_im_r <= num_im_nxt;
    den_r    <= den_nxt;
  end

  always_comb begin
    if (s1_op_r == cfpa_pkg::OP_SUB) begin
      as_re_nxt = $signed({ar_r[W-1], ar_r}) - $signed({br_r[W-1], br_r});
      as_im_nxt = $signed({ai_r[W-1], ai_r}) - $signed({bi_r[W-1], bi_r});
    end else begin
      as_re_nxt = $signed({ar_r[W-1], ar_r}) + $signed({br_r[W-1], br_r});
      as_im_nxt = $signed({ai_r[W-1], ai_r}) + $signed({bi_r[W-1], bi_r});
    end
  end

  logic signed [2*W:0] x_rr, x_ii, x_ri, x_ir, s_re, s_im, d_re, d_im, sh_re, sh_im;
  logic [2*W:0]        m_re, m_im;
  logic [W:0]          c_re, c_im;

  always_comb begin
    x_rr  = $signed({p_rr_r[2*W-1], p_rr_r});
    x_ii  = $signed({p_ii_r[2*W-1], p_ii_r});
    x_ri  = $signed({p_ri_r[2*W-1], p_ri_r});
    x_ir  = $signed({p_ir_r[2*W-1], p_ir_r});
    s_re  = x_rr - x_ii;
    s_im  = x_ri + x_ir;
    d_re  = x_rr + x_ii;
    d_im  = x_ir - x_ri;
    sh_re = s_re >>> FRAC_BITS;
    sh_im = s_im >>> FRAC_BITS;
    m_re  = d_re[2*W] ? (2*W+1)'(-d_re) : d_re;
    m_im  = d_im[2*W] ? (2*W+1)'(-d_im) : d_im;
    den_nxt    = {1'b0, q_rr_r} + {1'b0, q_ii_r};
    num_re_nxt = NW'(m_re) << FRAC_BITS;
    num_im_nxt = NW'(m_im) << FRAC_BITS;
    case (s2_op_r)
      cfpa_pkg::OP_MUL: begin
        c_re = clipw(sh_re);
        c_im = clipw(sh_im);
      end
      default: begin
        c_re = clipw({{W{as_re_r[W]}}, as_re_r});
        c_im = clipw({{W{as_im_r[W]}}, as_im_r});
      end
    endcase
    pre_re_nxt     = c_re[W-1:0];
    pre_im_nxt     = c_im[W-1:0];
    ctl_nxt.vld    = s2_vld_r;
    ctl_nxt.op     = s2_op_r;
    ctl_nxt.dz     = (s2_op_r == cfpa_pkg::OP_DIV) && (den_nxt == '0);
    ctl_nxt.sat    = c_re[W] | c_im[W];
    ctl_nxt.neg_re = d_re[2*W];
    ctl_nxt.neg_im = d_im[2*W];
  end

  assign ctl    = ctl_r;
  assign pre_re = pre_re_r;
  assign pre_im = pre_im_r;
  assign num_re = num_re_r;
  assign num_im = num_im_r;
  assign den    = den_r;

endmodule

// ===== design/cfpa_div.sv =====
module cfpa_div #(
  parameter int DATA_WIDTH = cfpa_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cfpa_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cfpa_pkg::ctl_t                  ctl_i,
  input  logic [DATA_WIDTH-1:0]           pre_re_i,
  input  logic [DATA_WIDTH-1:0]           pre_im_i,
  input  logic [2*DATA_WIDTH+FRAC_BITS:0] num_re_i,
  input  logic [2*DATA_WIDTH+FRAC_BITS:0] num_im_i,
  input  logic [2*DATA_WIDTH:0]           den_i,
  output cfpa_pkg::ctl_t                  ctl_o,
  output logic [DATA_WIDTH-1:0]           pre_re_o,
  output logic [DATA_WIDTH-1:0]           pre_im_o,
  output logic [DATA_WIDTH+1:0]           q_re_o,
  output logic [DATA_WIDTH+1:0]           q_im_o
);

  localparam int W  = DATA_WIDTH;
  localparam int NW = 2*W+1+FRAC_BITS;
  localparam int NS = W+2;

  cfpa_pkg::ctl_t  ctl_r    [NS];
  logic [W-1:0]    pre_re_r [NS];
  logic [W-1:0]    pre_im_r [NS];
  logic [NW-1:0]   rem_re_r [NS];
  logic [NW-1:0]   rem_im_r [NS];
  logic [2*W:0]    den_r    [NS];
  logic [W+1:0]    q_re_r   [NS];
  logic [W+1:0]    q_im_r   [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam int K = NS-1-g;
    cfpa_pkg::ctl_t ctl_in;
    logic [W-1:0]   pre_re_in, pre_im_in;
    logic [NW-1:0]  rem_re_in, rem_im_in, rem_re_nxt, rem_im_nxt, dsh;
    logic [2*W:0]   den_in;
    logic [W+1:0]   q_re_in, q_im_in;
    logic           ge_re, ge_im;

    if (g == 0) begin : g_head
      assign ctl_in    = ctl_i;
      assign pre_re_in = pre_re_i;
      assign pre_im_in = pre_im_i;
      assign rem_re_in = num_re_i;
      assign rem_im_in = num_im_i;
      assign den_in    = den_i;
      assign q_re_in   = '0;
      assign q_im_in   = '0;
    end else begin : g_body
      assign ctl_in    = ctl_r[g-1];
      assign pre_re_in = pre_re_r[g-1];
      assign pre_im_in = pre_im_r[g-1];
      assign rem_re_in = rem_re_r[g-1];
      assign rem_im_in = rem_im_r[g-1];
      assign den_in    = den_r[g-1];
      assign q_re_in   = q_re_r[g-1];
      assign q_im_in   = q_im_r[g-1];
    end

    always_comb begin
      dsh        = NW'(den_in) << K;
      ge_re      = (rem_re_in >> K) >= NW'(den_in);
      ge_im      = (rem_im_in >> K) >= NW'(den_in);
      rem_re_nxt = ge_re ? rem_re_in - dsh : rem_re_in;
      rem_im_nxt = ge_im ? rem_im_in - dsh : rem_im_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else begin
        ctl_r[g] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      pre_re_r[g] <= pre_re_in;
      pre_im_r[g] <= pre_im_in;
      rem_re_r[g] <= rem_re_nxt;
      rem_im_r[g] <= rem_im_nxt;
      den_r[g]    <= den_in;
      q_re_r[g]   <= {q_re_in[W:0], ge_re};
      q_im_r[g]   <= {q_im_in[W:0], ge_im};
    end
  end

  assign ctl_o    = ctl_r[NS-1];
  assign pre_re_o = pre_re_r[NS-1];
  assign pre_im_o = pre_im_r[NS-1];
  assign q_re_o   = q_re_r[NS-1];
  assign q_im_o   = q_im_r[NS-1];

endmodule

// ===== design/complex_fixed_point_alu_unit.sv =====
// Throughput: one request per cycle; busy stays low, the divider is one stage per quotient bit.
// Latency is set by three multiply/sum stages, DATA_WIDTH+2 divider stages and an output stage.
// Reset: synchronous, active low; clears all stage valid bits, no request is in flight.
// The receiver cannot stall: each result is on the out_ ports for exactly one cycle.
`include "complex_fixed_point_alu_unit_assert.svh"

module complex_fixed_point_alu_unit #(
  parameter int DATA_WIDTH = cfpa_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cfpa_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         out_strobe,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic                         out_saturated,
  output logic                         out_divide_by_zero
);

  localparam int W  = DATA_WIDTH;
  localparam int NW = 2*W+1+FRAC_BITS;
  localparam logic [W+1:0] TOPQ = (W+2)'(1) << (W-1);
  localparam logic [W-1:0] MAXR = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINR = {1'b1, {(W-1){1'b0}}};

  cfpa_pkg::ctl_t f_ctl, d_ctl;
  logic [W-1:0]   f_pre_re, f_pre_im, d_pre_re, d_pre_im;
  logic [NW-1:0]  f_num_re, f_num_im;
  logic [2*W:0]   f_den;
  logic [W+1:0]   d_q_re, d_q_im;

  assign busy = 1'b0;

  cfpa_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .req(start & ~busy), .action(in_action),
    .a_re(in_a_re), .a_im(in_a_im), .b_re(in_b_re), .b_im(in_b_im),
    .ctl(f_ctl), .pre_re(f_pre_re), .pre_im(f_pre_im),
    .num_re(f_num_re), .num_im(f_num_im), .den(f_den)
  );

  cfpa_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl_i(f_ctl), .pre_re_i(f_pre_re), .pre_im_i(f_pre_im),
    .num_re_i(f_num_re), .num_im_i(f_num_im), .den_i(f_den),
    .ctl_o(d_ctl), .pre_re_o(d_pre_re), .pre_im_o(d_pre_im),
    .q_re_o(d_q_re), .q_im_o(d_q_im)
  );

  function automatic logic [W:0] qclip(input logic neg, input logic [W+1:0] q);
    logic [W:0] r;
    if (neg) begin
      if (q > TOPQ) begin
        r = {1'b1, MINR};
      end else begin
        r = {1'b0, W'(-q[W-1:0])};
      end
    end else begin
      if (q > TOPQ - 1'b1) begin
        r = {1'b1, MAXR};
      end else begin
        r = {1'b0, q[W-1:0]};
      end
    end
    return r;
  endfunction

  logic         strobe_r, sat_r, dz_r, sat_nxt, dz_nxt;
  logic [W-1:0] re_r, im_r, re_nxt, im_nxt;
  logic [W:0]   c_re, c_im;

  always_comb begin
    c_re    = qclip(d_ctl.neg_re, d_q_re);
    c_im    = qclip(d_ctl.neg_im, d_q_im);
    re_nxt  = d_pre_re;
    im_nxt  = d_pre_im;
    sat_nxt = d_ctl.sat;
    dz_nxt  = 1'b0;
    if (d_ctl.op == cfpa_pkg::OP_DIV) begin
      if (d_ctl.dz) begin
        re_nxt  = '0;
        im_nxt  = '0;
        sat_nxt = 1'b0;
        dz_nxt  = 1'b1;
      end else begin
        re_nxt  = c_re[W-1:0];
        im_nxt  = c_im[W-1:0];
        sat_nxt = c_re[W] | c_im[W];
      end
    end
    if (!d_ctl.vld) begin
      sat_nxt = 1'b0;
      dz_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      sat_r    <= 1'b0;
      dz_r     <= 1'b0;
    end else begin
      strobe_r <= d_ctl.vld;
      sat_r    <= sat_nxt;
      dz_r     <= dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    re_r <= re_nxt;
    im_r <= im_nxt;
  end

  assign out_strobe         = strobe_r;
  assign out_res_re         = re_r;
  assign out_res_im         = im_r;
  assign out_saturated      = sat_r;
  assign out_divide_by_zero = dz_r;

  `CFPA_ASSERT_IMP(a_dz_zero, clk, rst_n, out_strobe && out_divide_by_zero, out_res_re == '0 && out_res_im == '0)
  `CFPA_ASSERT_IMP(a_dz_nosat, clk, rst_n, out_divide_by_zero, !out_saturated)
  `CFPA_ASSERT_IMP(a_idle_flags, clk, rst_n, !out_strobe, !out_saturated && !out_divide_by_zero)
  `CFPA_ASSERT_NXT(a_strobe_follow, clk, rst_n, d_ctl.vld, out_strobe)

endmodule
